// ===== rtl/omb_pkg.sv =====
// ----------------------------------------------------------------------------
// omb_pkg
// Types and constants shared by the overlapping box merger modules.
// ----------------------------------------------------------------------------
package omb_pkg;

  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int PROD_BITS  = 3 * COORD_BITS;
  localparam int PCT_BITS   = 7;

  localparam logic [PCT_BITS-1:0]   PCT_RESET   = PCT_BITS'(90);
  localparam logic [COORD_BITS-1:0] MERGE_SCALE = COORD_BITS'(100);

  typedef struct packed {
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic                  last_box;
  } box_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
  } box_t;

  localparam int BOX_BITS = $bits(box_t);

  typedef struct packed {
    logic [COORD_BITS-1:0] merged_left;
    logic [COORD_BITS-1:0] merged_top;
    logic [SIZE_BITS-1:0]  merged_width;
    logic [SIZE_BITS-1:0]  merged_height;
  } ubox_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] merged_left;
    logic [COORD_BITS-1:0] merged_top;
    logic [SIZE_BITS-1:0]  merged_width;
    logic [SIZE_BITS-1:0]  merged_height;
    logic                  box_present;
    logic                  list_overflow;
    logic                  last_result;
  } res_t;

  typedef struct packed {
    logic done;
    logic merge;
  } eval_stat_t;

endpackage

// ===== rtl/omb_ram.sv =====
// ----------------------------------------------------------------------------
// omb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module omb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/omb_pair_eval.sv =====
// ----------------------------------------------------------------------------
// omb_pair_eval
// Overlap test of two boxes on one shared multiplier, plus their union box.
// ----------------------------------------------------------------------------
module omb_pair_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  omb_pkg::box_t                 box_a,
  input  omb_pkg::box_t                 box_b,
  input  logic [omb_pkg::PCT_BITS-1:0]  pct,
  output omb_pkg::eval_stat_t           stat,
  output omb_pkg::ubox_t                union_box
);
  import omb_pkg::*;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_GEO  = 3'd1;
  localparam logic [2:0] E_M0   = 3'd2;
  localparam logic [2:0] E_M1   = 3'd3;
  localparam logic [2:0] E_M2   = 3'd4;
  localparam logic [2:0] E_M3   = 3'd5;
  localparam logic [2:0] E_M4   = 3'd6;
  localparam logic [2:0] E_CMP  = 3'd7;

  logic [2:0]            st_r, st_nxt;
  box_t                  a_r, a_nxt, b_r, b_nxt;
  logic [PCT_BITS-1:0]   pct_r, pct_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [AREA_BITS-1:0]  inter_r, inter_nxt, area_a_r, area_a_nxt, min_r, min_nxt;
  logic [PROD_BITS-1:0]  lhs_r, lhs_nxt, rhs_r, rhs_nxt;
  eval_stat_t            stat_r, stat_nxt;
  ubox_t                 union_r, union_nxt;

  // shared multiplier
  logic [AREA_BITS-1:0]  mul_a;
  logic [COORD_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]  prod;

  // geometry
  logic [SIZE_BITS-1:0]  ea_x, eb_x, ea_y, eb_y, x1, y1, ur, ud;
  logic [COORD_BITS-1:0] x0, y0, ux, uy;

  assign prod = mul_a * mul_b;

  always_comb begin
    ea_x = {1'b0, a_r.box_left} + {1'b0, a_r.box_width};
    eb_x = {1'b0, b_r.box_left} + {1'b0, b_r.box_width};
    ea_y = {1'b0, a_r.box_top} + {1'b0, a_r.box_height};
    eb_y = {1'b0, b_r.box_top} + {1'b0, b_r.box_height};
    x0   = (a_r.box_left > b_r.box_left) ? a_r.box_left : b_r.box_left;
    y0   = (a_r.box_top > b_r.box_top) ? a_r.box_top : b_r.box_top;
    x1   = (ea_x < eb_x) ? ea_x : eb_x;
    y1   = (ea_y < eb_y) ? ea_y : eb_y;
    ux   = (a_r.box_left < b_r.box_left) ? a_r.box_left : b_r.box_left;
    uy   = (a_r.box_top < b_r.box_top) ? a_r.box_top : b_r.box_top;
    ur   = (ea_x > eb_x) ? ea_x : eb_x;
    ud   = (ea_y > eb_y) ? ea_y : eb_y;
  end

  always_comb begin
    st_nxt     = st_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    pct_nxt    = pct_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    inter_nxt  = inter_r;
    area_a_nxt = area_a_r;
    min_nxt    = min_r;
    lhs_nxt    = lhs_r;
    rhs_nxt    = rhs_r;
    union_nxt  = union_r;
    stat_nxt   = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (st_r)
      E_IDLE: begin
        if (start) begin
          a_nxt   = box_a;
          b_nxt   = box_b;
          pct_nxt = pct;
          st_nxt  = E_GEO;
        end
      end
      E_GEO: begin
        dx_nxt = (x1 > {1'b0, x0}) ? COORD_BITS'(x1 - {1'b0, x0}) : '0;
        dy_nxt = (y1 > {1'b0, y0}) ? COORD_BITS'(y1 - {1'b0, y0}) : '0;
        union_nxt.merged_left   = ux;
        union_nxt.merged_top    = uy;
        union_nxt.merged_width  = ur - {1'b0, ux};
        union_nxt.merged_height = ud - {1'b0, uy};
        // no overlap in either axis can never merge
        if (x1 <= {1'b0, x0} || y1 <= {1'b0, y0}) begin
          stat_nxt.done = 1'b1;
          st_nxt        = E_IDLE;
        end else begin
          st_nxt = E_M0;
        end
      end
      E_M0: begin
        mul_a     = AREA_BITS'(dx_r);
        mul_b     = dy_r;
        inter_nxt = prod[AREA_BITS-1:0];
        st_nxt    = E_M1;
      end
      E_M1: begin
        mul_a      = AREA_BITS'(a_r.box_width);
        mul_b      = a_r.box_height;
        area_a_nxt = prod[AREA_BITS-1:0];
        st_nxt     = E_M2;
      end
      E_M2: begin
        mul_a   = AREA_BITS'(b_r.box_width);
        mul_b   = b_r.box_height;
        min_nxt = (prod[AREA_BITS-1:0] < area_a_r) ? prod[AREA_BITS-1:0] : area_a_r;
        st_nxt  = E_M3;
      end
      E_M3: begin
        mul_a   = inter_r;
        mul_b   = MERGE_SCALE;
        lhs_nxt = prod;
        st_nxt  = E_M4;
      end
      E_M4: begin
        mul_a   = min_r;
        mul_b   = COORD_BITS'(pct_r);
        rhs_nxt = prod;
        st_nxt  = E_CMP;
      end
      E_CMP: begin
        stat_nxt.done  = 1'b1;
        stat_nxt.merge = (lhs_r > rhs_r);
        st_nxt         = E_IDLE;
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      stat_r <= '0;
    end else begin
      st_r   <= st_nxt;
      stat_r <= stat_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    pct_r    <= pct_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    inter_r  <= inter_nxt;
    area_a_r <= area_a_nxt;
    min_r    <= min_nxt;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
    union_r  <= union_nxt;
  end

  assign stat      = stat_r;
  assign union_box = union_r;

endmodule

// ===== rtl/overlapping_box_merger.sv =====
// ----------------------------------------------------------------------------
// overlapping_box_merger
// Collects a list of boxes and, on the last one, merges overlapping pairs.
// ----------------------------------------------------------------------------
//   channel   ports                         handshake
//   input     start, busy, in_req           start && !busy
//   result    out_valid, out_res            out_valid, one cycle, no stall
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// a box without last_box is stored, or flagged when full. the last box starts
// the sweep over N stored boxes: each live outer box is read, then each stored
// box as its partner; dead or identical ones are skipped, a pair with no
// overlap ends at the geometry step, a full test runs all multiplies, and a
// final step closes the list, paced by the single multiplier and read port.
// reset is synchronous and needs no clearing pass; busy is high for the sweep.
// ----------------------------------------------------------------------------
module overlapping_box_merger #(
  parameter int MAX_BOXES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  omb_pkg::box_req_t            in_req,
  output logic                         out_valid,
  output omb_pkg::res_t                out_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [omb_pkg::PCT_BITS-1:0] cfg_data
);
  import omb_pkg::*;

  localparam int AW        = $clog2(MAX_BOXES);
  localparam int CW        = $clog2(MAX_BOXES + 1);
  localparam int WORD_BITS = BOX_BITS + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_A_RD   = 3'd1;
  localparam logic [2:0] ST_A_CAP  = 3'd2;
  localparam logic [2:0] ST_B_RD   = 3'd3;
  localparam logic [2:0] ST_B_CHK  = 3'd4;
  localparam logic [2:0] ST_EVAL   = 3'd5;
  localparam logic [2:0] ST_KILL_B = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt, i_r, i_nxt, j_r, j_nxt;
  logic                ovf_r, ovf_nxt;
  logic [PCT_BITS-1:0] pct_r, pct_nxt;
  box_t                a_r, a_nxt, b_r, b_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  ubox_t               pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_word;
  logic                 rd_dead;
  box_t                 rd_box, in_box;

  logic       ev_start;
  eval_stat_t ev_stat;
  ubox_t      ev_union;

  // each word is {dead, box}
  omb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_BOXES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  omb_pair_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ev_start),
    .box_a     (a_r),
    .box_b     (rd_box),
    .pct       (pct_r),
    .stat      (ev_stat),
    .union_box (ev_union)
  );

  assign rd_dead = rd_word[BOX_BITS];
  assign rd_box  = box_t'(rd_word[BOX_BITS-1:0]);

  always_comb begin
    in_box.box_left   = in_req.box_left;
    in_box.box_top    = in_req.box_top;
    in_box.box_width  = in_req.box_width;
    in_box.box_height = in_req.box_height;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    ovf_nxt        = ovf_r;
    pct_nxt        = pct_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    ev_start       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          pct_nxt = cfg_data;
        end
        if (start) begin
          if (count_r < CW'(MAX_BOXES)) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[AW-1:0];
            wr_data   = {1'b0, in_box};
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_req.last_box) begin
            i_nxt          = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_A_RD;
          end
        end
      end
      ST_A_RD: begin
        if (i_r >= count_r) begin
          state_nxt = ST_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          state_nxt = ST_A_CAP;
        end
      end
      ST_A_CAP: begin
        a_nxt = rd_box;
        if (rd_dead) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_A_RD;
        end else begin
          j_nxt     = '0;
          state_nxt = ST_B_RD;
        end
      end
      ST_B_RD: begin
        if (j_r >= count_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_A_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = j_r[AW-1:0];
          state_nxt = ST_B_CHK;
        end
      end
      ST_B_CHK: begin
        b_nxt = rd_box;
        // identical boxes, the outer box itself included, are skipped
        if (rd_dead || rd_box == a_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_B_RD;
        end else begin
          ev_start  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (ev_stat.done) begin
          if (ev_stat.merge) begin
            wr_en   = 1'b1;
            wr_addr = i_r[AW-1:0];
            wr_data = {1'b1, a_r};
            // hold the newest merge back until we know whether it is the last
            if (pend_valid_r) begin
              out_valid_nxt               = 1'b1;
              out_res_nxt.merged_left     = pend_r.merged_left;
              out_res_nxt.merged_top      = pend_r.merged_top;
              out_res_nxt.merged_width    = pend_r.merged_width;
              out_res_nxt.merged_height   = pend_r.merged_height;
              out_res_nxt.box_present     = 1'b1;
              out_res_nxt.list_overflow   = ovf_r;
              out_res_nxt.last_result     = 1'b0;
            end
            pend_nxt       = ev_union;
            pend_valid_nxt = 1'b1;
            state_nxt      = ST_KILL_B;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = ST_B_RD;
          end
        end
      end
      ST_KILL_B: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[AW-1:0];
        wr_data   = {1'b1, b_r};
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_A_RD;
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        if (pend_valid_r) begin
          out_res_nxt.merged_left   = pend_r.merged_left;
          out_res_nxt.merged_top    = pend_r.merged_top;
          out_res_nxt.merged_width  = pend_r.merged_width;
          out_res_nxt.merged_height = pend_r.merged_height;
          out_res_nxt.box_present   = 1'b1;
        end else begin
          out_res_nxt.merged_left   = '0;
          out_res_nxt.merged_top    = '0;
          out_res_nxt.merged_width  = '0;
          out_res_nxt.merged_height = '0;
          out_res_nxt.box_present   = 1'b0;
        end
        out_res_nxt.list_overflow = ovf_r;
        out_res_nxt.last_result   = 1'b1;
        count_nxt      = '0;
        ovf_nxt        = 1'b0;
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      pct_r        <= PCT_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      pct_r        <= pct_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef ASSERT_OFF
  a_last_ends_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last_result |-> !busy)
    else $error("final result seen while the sweep is still running");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.box_present |-> out_res.last_result)
    else $error("terminator without last_result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_req.last_box && count_r == CW'(MAX_BOXES) |=> ovf_r)
    else $error("dropped box not flagged");

  a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.box_present |->
      out_res.merged_width != '0 && out_res.merged_height != '0)
    else $error("merged box with empty extent");
`endif

endmodule
